// ===== hw/rtl/stack_alu_engine_assert.svh =====
// Assertion macros used by the stack ALU engine datapath.
`ifndef STACK_ALU_ENGINE_ASSERT_SVH
`define STACK_ALU_ENGINE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SAE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SAE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sae_pkg.sv =====
package sae_pkg;

    localparam logic [3:0] MODE_PUSH  = 4'd0;
    localparam logic [3:0] MODE_ADD   = 4'd1;
    localparam logic [3:0] MODE_SUB   = 4'd2;
    localparam logic [3:0] MODE_MUL   = 4'd3;
    localparam logic [3:0] MODE_DIV   = 4'd4;
    localparam logic [3:0] MODE_MOD   = 4'd5;
    localparam logic [3:0] MODE_AND   = 4'd6;
    localparam logic [3:0] MODE_OR    = 4'd7;
    localparam logic [3:0] MODE_XOR   = 4'd8;
    localparam logic [3:0] MODE_NOT   = 4'd9;
    localparam logic [3:0] MODE_NAND  = 4'd10;
    localparam logic [3:0] MODE_NOR   = 4'd11;
    localparam logic [3:0] MODE_XNOR  = 4'd12;
    localparam logic [3:0] MODE_POP   = 4'd13;
    localparam logic [3:0] MODE_CLEAR = 4'd14;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch request, read top
        logic mul_start;  // clear product accumulator
        logic mul_step;   // one 16-bit partial product
        logic div_start;  // set up divider
        logic div_step;   // one quotient bit
        logic commit;     // write result to stack and output
    } sae_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
    } sae_sts_t;

endpackage

// ===== hw/rtl/sae_ctrl.sv =====
module sae_ctrl
    import sae_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  sae_sts_t sts,
    output sae_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       mv_reg, mv_next;

    // Output register frees once the pending result is taken.
    assign s_ready = (state_reg == ST_IDLE) && (!mv_reg || m_ready);
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                cnt_next = 6'd0;
                if (sts.is_mul) begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end else if (sts.is_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3) state_next = ST_DONE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 6'd0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

// ===== hw/rtl/sae_dpath.sv =====
module sae_dpath
    import sae_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sae_cmd_t           cmd,
    output sae_sts_t           sts,
    input  logic [3:0]         s_mode,
    input  logic signed [63:0] s_operand_value,
    output logic signed [63:0] m_result_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0] m_stack_depth,
    output logic               m_underflow_flag,
    output logic               m_divide_by_zero_flag,
    output logic               m_overflow_flag
);
    `include "stack_alu_engine_assert.svh"

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

    logic [63:0] mem [STACK_DEPTH];
    logic [PW-1:0] sp_reg;
    logic [3:0]  mode_reg;
    logic [63:0] v_reg, top_reg, acc_reg, quo_reg, rem_reg, dvs_reg;
    logic        neg_q_reg, neg_r_reg;
    logic [1:0]  mcnt_reg;
    logic [AW-1:0] rd_addr;

    assign rd_addr = AW'(sp_reg - PW'(1));

    // Registered read of the current top.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            top_reg  <= (sp_reg == '0) ? 64'd0 : mem[rd_addr];
            mode_reg <= s_mode;
            v_reg    <= s_operand_value;
        end
    end

    logic is_bin, dz;
    assign is_bin = (mode_reg >= MODE_ADD) && (mode_reg <= MODE_XNOR) && (mode_reg != MODE_NOT);
    assign dz = ((mode_reg == MODE_DIV) || (mode_reg == MODE_MOD)) && (v_reg == 64'd0);
    assign sts.is_mul = (mode_reg == MODE_MUL);
    assign sts.is_div = (mode_reg == MODE_DIV || mode_reg == MODE_MOD) && !dz;

    // 64x16 partial product per step, four steps.
    logic [15:0] mslice;
    logic [63:0] pp;
    always_comb begin
        mslice = 16'(v_reg >> {mcnt_reg, 4'd0});
        pp     = (top_reg * {48'd0, mslice}) << {mcnt_reg, 4'd0};
    end

    // Restoring divider, one quotient bit per step.
    logic [64:0] trial;
    logic [63:0] rsh;
    assign rsh   = {rem_reg[62:0], quo_reg[63]};
    assign trial = {1'b0, rsh} - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            acc_reg  <= 64'd0;
            mcnt_reg <= 2'd0;
        end else if (cmd.mul_step) begin
            acc_reg  <= acc_reg + pp;
            mcnt_reg <= mcnt_reg + 2'd1;
        end
        if (cmd.div_start) begin
            quo_reg   <= top_reg[63] ? -top_reg : top_reg;
            dvs_reg   <= v_reg[63] ? -v_reg : v_reg;
            rem_reg   <= 64'd0;
            neg_q_reg <= top_reg[63] ^ v_reg[63];
            neg_r_reg <= top_reg[63];
        end else if (cmd.div_step) begin
            if (!trial[64]) begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= rsh;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    logic [63:0] alu;
    always_comb begin
        case (mode_reg)
            MODE_ADD:  alu = top_reg + v_reg;
            MODE_SUB:  alu = top_reg - v_reg;
            MODE_MUL:  alu = acc_reg;
            MODE_DIV:  alu = neg_q_reg ? -quo_reg : quo_reg;
            MODE_MOD:  alu = neg_r_reg ? -rem_reg : rem_reg;
            MODE_AND:  alu = top_reg & v_reg;
            MODE_OR:   alu = top_reg | v_reg;
            MODE_XOR:  alu = top_reg ^ v_reg;
            MODE_NAND: alu = ~(top_reg & v_reg);
            MODE_NOR:  alu = ~(top_reg | v_reg);
            default:   alu = ~(top_reg ^ v_reg);
        endcase
    end

    logic [PW-1:0] sp_new;
    logic          wr_en, uf, of;
    logic [63:0]   wr_data, res;
    always_comb begin
        sp_new  = sp_reg;
        wr_en   = 1'b0;
        wr_data = alu;
        uf      = 1'b0;
        of      = 1'b0;
        res     = top_reg;
        if (mode_reg == MODE_PUSH || mode_reg == MODE_NOT) begin
            wr_data = (mode_reg == MODE_NOT) ? ~v_reg : v_reg;
            if (sp_reg == FULL) begin
                of = 1'b1;
            end else begin
                wr_en  = 1'b1;
                sp_new = sp_reg + PW'(1);
                res    = wr_data;
            end
        end else if (mode_reg == MODE_POP) begin
            if (sp_reg == '0) uf = 1'b1;
            else sp_new = sp_reg - PW'(1);
        end else if (mode_reg == MODE_CLEAR) begin
            sp_new = '0;
            res    = 64'd0;
        end else if (is_bin && !dz) begin
            // replaces top, or pushes onto empty stack
            wr_en = 1'b1;
            res   = alu;
            if (sp_reg == '0) begin
                uf     = 1'b1;
                sp_new = PW'(1);
            end
        end
    end

    // Pushes and ops on an empty stack land at the pointer; other ops overwrite the top.
    logic [AW-1:0] wr_addr;
    assign wr_addr = (mode_reg == MODE_PUSH || mode_reg == MODE_NOT || sp_reg == '0) ?
                     AW'(sp_reg) : rd_addr;

    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) mem[wr_addr] <= wr_data;
        if (cmd.commit) begin
            m_result_value        <= res;
            m_stack_depth         <= sp_new;
            m_underflow_flag      <= uf;
            m_divide_by_zero_flag <= dz;
            m_overflow_flag       <= of;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) sp_reg <= '0;
        else if (cmd.commit) sp_reg <= sp_new;
    end

    `SAE_ASSERT_IMPL(a_sp_range, aclk, aresetn, 1'b1, sp_reg <= FULL, "stack pointer out of range")
    `SAE_ASSERT_IMPL(a_of_full, aclk, aresetn, cmd.commit && of, sp_reg == FULL, "overflow while not full")
    `SAE_ASSERT_NEXT(a_sp_hold, aclk, aresetn, !cmd.commit, $stable(sp_reg), "pointer moved without commit")

endmodule

// ===== hw/rtl/stack_alu_engine.sv =====
// Stack ALU engine: 64-bit operand stack with add/sub/mul/div/mod and logic ops.
// Steps: load and read top, decode, then four 64x16 partial products for mul
//   or a restoring divider (one quotient bit per cycle) for div/mod, commit.
// One request at a time: no new one is taken until the result is committed.
// Reset: aresetn synchronous active low; empties the stack, clears output valid.
module stack_alu_engine
    import sae_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_mode,
    input  logic signed [63:0] s_operand_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_result_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0] m_stack_depth,
    output logic               m_underflow_flag,
    output logic               m_divide_by_zero_flag,
    output logic               m_overflow_flag
);

    sae_cmd_t cmd;
    sae_sts_t sts;

    // Controller sequences load, multiply/divide iterations and commit.
    sae_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath holds the stack memory, pointer, ALU, multiplier and divider.
    sae_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .sts                   (sts),
        .s_mode                (s_mode),
        .s_operand_value       (s_operand_value),
        .m_result_value        (m_result_value),
        .m_stack_depth         (m_stack_depth),
        .m_underflow_flag      (m_underflow_flag),
        .m_divide_by_zero_flag (m_divide_by_zero_flag),
        .m_overflow_flag       (m_overflow_flag)
    );

endmodule
